FILE: rtl/core/indexed_pixel_colorizer_defines.svh
// Assertion macros for the indexed pixel colorizer.
// Uses the clk and rst_n names of the module in which a macro is expanded.
`ifndef INDEXED_PIXEL_COLORIZER_DEFINES_SVH
`define INDEXED_PIXEL_COLORIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define IPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colorizer check failed");
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colorizer check failed");
`else
`define IPC_ASSERT_NOW(lbl, ante, cons)
`define IPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/ipc_pkg.sv
// Shared types, constants and helper functions of the indexed pixel colorizer.
// No dependencies.
package ipc_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MATERIAL_COLORS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_VALUES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUST_DATA         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_REGULAR     = 3'd5;

  localparam logic [31:0] LCG_MULT      = 32'd1103515245;
  localparam logic [31:0] LCG_INC       = 32'd12345;
  localparam logic [10:0] CHAN_MAX      = 11'h7FF;
  localparam logic [7:0]  MATERIAL_BASE = 8'd192;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

  typedef enum logic [1:0] {
    PIX_PALETTE,
    PIX_MATERIAL,
    PIX_TRANSPARENT
  } pix_kind_t;

  typedef struct packed {
    logic [63:0] material_colors;
    logic [31:0] alpha_values;
    logic [7:0]  base_alpha;
    logic [31:0] rust_data;
    logic [15:0] key_color;
    logic        allow_regular;
  } cfg_t;

  // One pixel as it crosses from the front end to the back end.
  typedef struct packed {
    pix_kind_t   kind;
    logic [15:0] color;
    logic [1:0]  mat_sel;
    logic [3:0]  shade;
    logic        dim;
  } mid_entry_t;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        alpha_valid;
  } out_entry_t;

  function automatic logic [15:0] pack_rgb888(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

  function automatic logic [10:0] sat11(input logic [13:0] v);
    return (v > {3'b000, CHAN_MAX}) ? CHAN_MAX : v[10:0];
  endfunction

endpackage

FILE: rtl/core/indexed_pixel_colorizer.sv
// Indexed pixel colorizer, top level: configuration registers, front end, queue, back end.
// A pixel beat passes the front-end stage register, the queue and the output queue on its way to the result ports.
// Throughput is one beat per cycle while in_full is low; palette write beats give no result.
// The rust seed update (one 32-bit multiply-add per pixel) sets the front-end cycle time.
// Synchronous active-low reset restores register defaults and clears seeds and queues.
// Palette contents are not cleared by reset.
`include "indexed_pixel_colorizer_defines.svh"

module indexed_pixel_colorizer #(
  parameter int MID_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_pixel_index,
  input  logic [23:0] in_palette_rgb,
  input  logic        in_first_of_image,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_color,
  output logic [7:0]  out_alpha,
  output logic        out_alpha_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import ipc_pkg::*;

  localparam int CntW = $clog2(MID_DEPTH + 1);

  cfg_t            cfg_r;
  logic            cfg_write;
  logic            mid_push, mid_pop;
  mid_entry_t      mid_in, mid_head;
  logic [CntW-1:0] mid_count;

  assign cfg_ready = rst_n;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.material_colors   <= '0;
      cfg_r.alpha_values      <= '1;
      cfg_r.base_alpha        <= ALPHA_OPAQUE;
      cfg_r.rust_data         <= '0;
      cfg_r.key_color         <= 16'hF81F;
      cfg_r.allow_regular     <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MATERIAL_COLORS:   cfg_r.material_colors   <= cfg_data;
        CFG_ALPHA_VALUES:      cfg_r.alpha_values      <= cfg_data[31:0];
        CFG_BASE_ALPHA:        cfg_r.base_alpha        <= cfg_data[7:0];
        CFG_RUST_DATA:         cfg_r.rust_data         <= cfg_data[31:0];
        CFG_KEY_COLOR:         cfg_r.key_color         <= cfg_data[15:0];
        CFG_ALLOW_REGULAR:     cfg_r.allow_regular     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ipc_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_pixel_index    (in_pixel_index),
    .in_palette_rgb    (in_palette_rgb),
    .in_first_of_image (in_first_of_image),
    .mid_count         (mid_count),
    .mid_push          (mid_push),
    .mid_entry         (mid_in)
  );

  ipc_queue #(.DEPTH(MID_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (mid_push),
    .push_entry (mid_in),
    .pop        (mid_pop),
    .head       (mid_head),
    .count      (mid_count)
  );

  ipc_back #(.MID_DEPTH(MID_DEPTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .mid_head        (mid_head),
    .mid_count       (mid_count),
    .mid_pop         (mid_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_color       (out_color),
    .out_alpha       (out_alpha),
    .out_alpha_valid (out_alpha_valid)
  );

  // The staged pixel must always find a free slot in the queue.
  `IPC_ASSERT_NOW(a_mid_room, mid_push, mid_count < CntW'(MID_DEPTH))
  `IPC_ASSERT_NEXT(a_pixel_staged, in_push && !in_full && in_op, mid_push)
  `IPC_ASSERT_NEXT(a_result_kept, !out_empty && !out_pop, !out_empty)

endmodule

FILE: rtl/core/ipc_queue.sv
// Small circular queue that decouples the front end from the back end.
// Depends on ipc_pkg for the entry type.
module ipc_queue #(
  parameter int DEPTH = 4,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipc_pkg::mid_entry_t  push_entry,
  input  logic                 pop,
  output ipc_pkg::mid_entry_t  head,
  output logic [CntW-1:0]      count
);
  import ipc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mid_entry_t            store [DEPTH];
  logic [PtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       count_r, count_nxt;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = store[rd_ptr_r];
  assign count = count_r;

endmodule

FILE: rtl/core/ipc_front.sv
// Front end: takes input beats, holds the palette and the rust generators,
// and classifies each pixel. Depends on ipc_pkg.
module ipc_front #(
  parameter int MID_DEPTH = 4,
  localparam int CntW = $clog2(MID_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::cfg_t       cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_op,
  input  logic [7:0]          in_pixel_index,
  input  logic [23:0]         in_palette_rgb,
  input  logic                in_first_of_image,
  input  logic [CntW-1:0]     mid_count,
  output logic                mid_push,
  output ipc_pkg::mid_entry_t mid_entry
);
  import ipc_pkg::*;

  logic [23:0]  palette_mem [256];
  logic [23:0]  pal_rdata_r;

  logic [31:0]  seeds_r   [4];
  logic [31:0]  seeds_nxt [4];

  logic         stage_valid_r, stage_valid_nxt;
  pix_kind_t    stage_kind_r;
  logic [1:0]   stage_sel_r;
  logic [3:0]   stage_shade_r;
  logic         stage_dim_r;

  logic [CntW:0] fill;
  logic          accept, pix_accept, pal_write;
  logic          is_material, mat_opaque, rust_on, dim;
  logic [1:0]    sel;
  logic [15:0]   mat_color;
  logic [7:0]    rust_byte;
  logic [31:0]   seed_base, seed_new;
  pix_kind_t     kind;

  // Room is reserved for the pixel held in the stage register as well.
  assign fill       = {1'b0, mid_count} + {{CntW{1'b0}}, stage_valid_r};
  assign in_full    = !rst_n || (fill >= (CntW + 1)'(MID_DEPTH));
  assign accept     = in_push && !in_full;
  assign pix_accept = accept && in_op;
  assign pal_write  = accept && !in_op;

  always_comb begin
    sel         = in_pixel_index[5:4];
    is_material = in_pixel_index >= MATERIAL_BASE;
    mat_color   = cfg.material_colors[16*sel +: 16];
    rust_byte   = cfg.rust_data[8*sel +: 8];
    mat_opaque  = is_material && (mat_color != cfg.key_color);
    rust_on     = mat_opaque && (cfg.rust_data != '0) && (rust_byte != '0);
    // A first-of-image pixel sees its seed freshly reloaded.
    seed_base   = in_first_of_image ? {26'd0, rust_byte[7:2]} : seeds_r[sel];
    seed_new    = seed_base * LCG_MULT + LCG_INC;
    dim         = rust_byte[1:0] > seed_new[31:30];

    if (is_material) begin
      kind = mat_opaque ? PIX_MATERIAL : PIX_TRANSPARENT;
    end else begin
      kind = cfg.allow_regular ? PIX_PALETTE : PIX_TRANSPARENT;
    end

    for (int i = 0; i < 4; i++) begin
      seeds_nxt[i] = seeds_r[i];
      if (pix_accept && in_first_of_image) begin
        seeds_nxt[i] = {26'd0, cfg.rust_data[8*i+2 +: 6]};
      end
      if (pix_accept && rust_on && (sel == 2'(i))) begin
        seeds_nxt[i] = seed_new;
      end
    end

    stage_valid_nxt = pix_accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        seeds_r[i] <= '0;
      end
    end else begin
      stage_valid_r <= stage_valid_nxt;
      seeds_r       <= seeds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      stage_kind_r  <= kind;
      stage_sel_r   <= sel;
      stage_shade_r <= in_pixel_index[3:0];
      stage_dim_r   <= rust_on && dim;
    end
  end

  // Palette memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pal_write) begin
      palette_mem[in_pixel_index] <= in_palette_rgb;
    end
    if (pix_accept) begin
      pal_rdata_r <= palette_mem[in_pixel_index];
    end
  end

  always_comb begin
    mid_entry.kind    = stage_kind_r;
    mid_entry.mat_sel = stage_sel_r;
    mid_entry.shade   = stage_shade_r;
    mid_entry.dim     = stage_dim_r;
    case (stage_kind_r)
      PIX_PALETTE: mid_entry.color = pack_rgb888(pal_rdata_r);
      default:     mid_entry.color = cfg.key_color;
    endcase
  end

  assign mid_push = stage_valid_r;

endmodule

FILE: rtl/core/ipc_back.sv
// Back end: shades material pixels, applies rust dimming, picks the alpha and
// holds finished results in a two-entry output queue. Depends on ipc_pkg.
module ipc_back #(
  parameter int MID_DEPTH = 4,
  localparam int CntW = $clog2(MID_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::cfg_t       cfg,
  input  ipc_pkg::mid_entry_t mid_head,
  input  logic [CntW-1:0]     mid_count,
  output logic                mid_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [15:0]         out_color,
  output logic [7:0]          out_alpha,
  output logic                out_alpha_valid
);
  import ipc_pkg::*;

  out_entry_t  res_q [2];
  logic        wr_sel_r, rd_sel_r;
  logic [1:0]  res_cnt_r, res_cnt_nxt;
  logic        res_pop, room;

  logic [15:0] mc;
  logic [11:0] red_p, green_p, blue_p;
  logic [13:0] red_w, green_w, blue_w, green_x3;
  logic [10:0] red_s, green_s, blue_s;
  logic        use_alpha;
  out_entry_t  result;

  always_comb begin
    mc       = cfg.material_colors[16*mid_head.mat_sel +: 16];
    red_p    = {4'd0, mc[15:11], 3'd0} * {8'd0, mid_head.shade};
    green_p  = {4'd0, mc[10:5], 2'd0} * {8'd0, mid_head.shade};
    blue_p   = {4'd0, mc[4:0], 3'd0} * {8'd0, mid_head.shade};
    green_x3 = {2'd0, green_p} * 14'd3;
    red_w    = {2'd0, red_p};
    if (mid_head.dim) begin
      green_w = green_x3 >> 2;
      blue_w  = {3'd0, blue_p[11:1]};
    end else begin
      green_w = {2'd0, green_p};
      blue_w  = {2'd0, blue_p};
    end
    red_s   = sat11(red_w);
    green_s = sat11(green_w);
    blue_s  = sat11(blue_w);

    use_alpha = (cfg.base_alpha != ALPHA_OPAQUE) || (cfg.alpha_values != '1);

    case (mid_head.kind)
      PIX_MATERIAL: begin
        result.color = {red_s[10:6], green_s[10:5], blue_s[10:6]};
        result.alpha = cfg.alpha_values[8*mid_head.mat_sel +: 8];
      end
      default: begin
        result.color = mid_head.color;
        result.alpha = cfg.base_alpha;
      end
    endcase
    if (!use_alpha) begin
      result.alpha = '0;
    end
    result.alpha_valid = use_alpha;
  end

  // A slot frees up in the same cycle that the oldest result beat is taken.
  assign res_pop     = out_pop && (res_cnt_r != 2'd0);
  assign room        = (res_cnt_r != 2'd2) || out_pop;
  assign mid_pop     = (mid_count != '0) && room;
  assign res_cnt_nxt = res_cnt_r + 2'(mid_pop) - 2'(res_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r  <= 1'b0;
      rd_sel_r  <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      wr_sel_r  <= wr_sel_r ^ mid_pop;
      rd_sel_r  <= rd_sel_r ^ res_pop;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      res_q[wr_sel_r] <= result;
    end
  end

  assign out_empty       = (res_cnt_r == 2'd0);
  assign out_color       = res_q[rd_sel_r].color;
  assign out_alpha       = res_q[rd_sel_r].alpha;
  assign out_alpha_valid = res_q[rd_sel_r].alpha_valid;

endmodule

FILE: sim/indexed_pixel_colorizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_pixel_colorizer: palette writes, material shading,
// rust dimming and alpha output, checked beat by beat against a behavioural predictor.
// Depends on ipc_pkg and the indexed_pixel_colorizer RTL only.
module indexed_pixel_colorizer_tb;
  import ipc_pkg::*;

  localparam logic        OP_PALETTE_WRITE = 1'b0;
  localparam logic        OP_COLORIZE      = 1'b1;
  localparam logic [7:0]  FIRST_MATERIAL   = 8'd192;
  localparam logic [31:0] SEED_MUL         = 32'd1103515245;
  localparam logic [31:0] SEED_ADD         = 32'd12345;
  localparam logic [13:0] CHANNEL_LIMIT    = 14'h7FF;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          BEATS_PER_PHASE  = 310;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = 1'b0;
  logic [7:0]  in_pixel_index = '0;
  logic [23:0] in_palette_rgb = '0;
  logic        in_first_of_image = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_color;
  logic [7:0]  out_alpha;
  logic        out_alpha_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Predictor state.
  cfg_t        active_cfg;
  logic [23:0] palette_shadow [256];
  logic        palette_written [256];
  int          written_regular [$];
  logic [31:0] rust_seed [4];
  out_entry_t  expected_pixels [$];

  int tx_idle_pct = 26;
  int rx_idle_pct = 71;
  int mismatch_count = 0;
  int pixels_checked = 0;
  int palette_writes = 0;
  int material_pixels = 0;
  int rust_dims = 0;
  int settings_applied = 0;

  indexed_pixel_colorizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_op            (in_op),
    .in_pixel_index   (in_pixel_index),
    .in_palette_rgb   (in_palette_rgb),
    .in_first_of_image(in_first_of_image),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_color        (out_color),
    .out_alpha        (out_alpha),
    .out_alpha_valid  (out_alpha_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [13:0] clamp_channel(input logic [13:0] v);
    return (v > CHANNEL_LIMIT) ? CHANNEL_LIMIT : v;
  endfunction

  // Works out the result of one pixel beat and advances the rust generators.
  function automatic out_entry_t colorize(input logic [7:0] idx, input logic first);
    out_entry_t  res;
    logic [1:0]  sel;
    logic [15:0] mat;
    logic [7:0]  rbyte;
    logic [23:0] entry;
    logic [13:0] red, green, blue;
    logic [7:0]  alpha;
    logic [15:0] color;
    logic        alpha_on;
    alpha_on = (active_cfg.base_alpha != 8'hFF) || (active_cfg.alpha_values != 32'hFFFF_FFFF);
    alpha = active_cfg.base_alpha;
    if (first) begin
      for (int i = 0; i < 4; i++) rust_seed[i] = {26'd0, active_cfg.rust_data[8*i+2 +: 6]};
    end
    if (idx >= FIRST_MATERIAL) begin
      sel = idx[5:4];
      mat = active_cfg.material_colors[16*sel +: 16];
      material_pixels++;
      if (mat != active_cfg.key_color) begin
        red   = {6'd0, mat[15:11], 3'd0} * idx[3:0];
        green = {6'd0, mat[10:5], 2'd0} * idx[3:0];
        blue  = {6'd0, mat[4:0], 3'd0} * idx[3:0];
        rbyte = active_cfg.rust_data[8*sel +: 8];
        if (active_cfg.rust_data != 32'd0 && rbyte != 8'd0) begin
          rust_seed[sel] = rust_seed[sel] * SEED_MUL + SEED_ADD;
          if ({30'd0, rbyte[1:0]} > {30'd0, rust_seed[sel][31:30]}) begin
            green = (green * 14'd3) >> 2;
            blue  = blue >> 1;
            rust_dims++;
          end
        end
        red   = clamp_channel(red);
        green = clamp_channel(green);
        blue  = clamp_channel(blue);
        color = {red[10:6], green[10:5], blue[10:6]};
        alpha = active_cfg.alpha_values[8*sel +: 8];
      end else begin
        color = active_cfg.key_color;
      end
    end else if (active_cfg.allow_regular) begin
      entry = palette_shadow[idx];
      color = {entry[23:19], entry[15:10], entry[7:3]};
    end else begin
      color = active_cfg.key_color;
    end
    res.color = color;
    res.alpha = alpha_on ? alpha : 8'd0;
    res.alpha_valid = alpha_on;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("Mismatch on %s of pixel %0d: got %h, expected %h",
             what, pixels_checked, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_entry_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat", out_color, 16'h0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_color !== want.color) report_mismatch("color", out_color, want.color);
        if (out_alpha !== want.alpha) report_mismatch("alpha", out_alpha, want.alpha);
        if (out_alpha_valid !== want.alpha_valid)
          report_mismatch("alpha_valid", out_alpha_valid, want.alpha_valid);
      end
      pixels_checked++;
    end
  end

  // Sends one beat, with random idle cycles ahead of it, and predicts its result or records its palette write.
  task automatic send_beat(input logic op, input logic [7:0] idx, input logic [23:0] rgb,
                           input logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_pixel_index <= idx;
    in_palette_rgb <= rgb;
    in_first_of_image <= first;
    do @(posedge clk); while (in_full);
    if (op == OP_PALETTE_WRITE) begin
      palette_shadow[idx] = rgb;
      if (!palette_written[idx] && idx < FIRST_MATERIAL) written_regular.push_back(int'(idx));
      palette_written[idx] = 1'b1;
      palette_writes++;
    end else begin
      expected_pixels.push_back(colorize(idx, first));
    end
  endtask

  // Palette write beats give no result, so allow the pipeline to settle after the last one.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [63:0]          data;
    for (int r = CFG_MATERIAL_COLORS; r <= CFG_ALLOW_REGULAR; r++) begin
      reg_idx = CFG_IDX_W'(r);
      case (reg_idx)
        CFG_MATERIAL_COLORS:   data = s.material_colors;
        CFG_ALPHA_VALUES:      data = 64'(s.alpha_values);
        CFG_BASE_ALPHA:        data = 64'(s.base_alpha);
        CFG_RUST_DATA:         data = 64'(s.rust_data);
        CFG_KEY_COLOR:         data = 64'(s.key_color);
        default:               data = 64'(s.allow_regular);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx;
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    active_cfg = s;
    settings_applied++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    int   pick;
    s.material_colors = {$urandom, $urandom};
    s.alpha_values = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom;
    s.base_alpha = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
    s.rust_data = $urandom;
    for (int i = 0; i < 4; i++)
      if ($urandom_range(3) == 0) s.rust_data[8*i +: 8] = 8'd0;
    pick = $urandom_range(3);
    s.key_color = $urandom_range(1) ? s.material_colors[16*pick +: 16] : 16'($urandom);
    s.allow_regular = 1'($urandom_range(1));
    return s;
  endfunction

  // Runs under the reset register values, so it also checks them.
  task automatic test_palette_extremes();
    send_beat(OP_PALETTE_WRITE, 8'd0, 24'h000000, 1'b0);
    send_beat(OP_PALETTE_WRITE, 8'd191, 24'hFFFFFF, 1'b1);
    send_beat(OP_PALETTE_WRITE, 8'd100, 24'h123456, 1'b0);
    send_beat(OP_PALETTE_WRITE, 8'd255, 24'hA5A5A5, 1'b1);
    send_beat(OP_COLORIZE, 8'd0, 24'hFFFFFF, 1'b0);
    send_beat(OP_COLORIZE, 8'd191, 24'h000000, 1'b1);
    send_beat(OP_COLORIZE, 8'd100, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd255, 24'h0, 1'b0);
  endtask

  task automatic test_materials_and_shades();
    cfg_t s;
    s.material_colors = {16'h0000, 16'h8410, 16'hF81F, 16'hFFFF};
    s.alpha_values = 32'h0080_55C3;
    s.base_alpha = 8'h40;
    s.rust_data = 32'd0;
    s.key_color = 16'hF81F;
    s.allow_regular = 1'b1;
    wait_drained();
    apply_settings(s);
    send_beat(OP_COLORIZE, 8'd192, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd207, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd200, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd208, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd234, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd255, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd0, 24'h0, 1'b0);
    // With regular colours off the palette entry does not reach the result, so unwritten entries are fine.
    s.allow_regular = 1'b0;
    wait_drained();
    apply_settings(s);
    send_beat(OP_COLORIZE, 8'd191, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd5, 24'h0, 1'b0);
  endtask

  task automatic test_rust_effect();
    cfg_t s;
    s.material_colors = {16'h07E0, 16'hFFFF, 16'hF800, 16'hFFFF};
    s.alpha_values = 32'hFFFF_FFFF;
    s.base_alpha = 8'hFF;
    s.rust_data = 32'hFF00_03FD;
    s.key_color = 16'hF81F;
    s.allow_regular = 1'b1;
    wait_drained();
    apply_settings(s);
    send_beat(OP_COLORIZE, 8'd207, 24'h0, 1'b1);
    send_beat(OP_COLORIZE, 8'd207, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd207, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd223, 24'h0, 1'b0);
    // A palette write carrying first_of_image must not reload the seeds.
    send_beat(OP_PALETTE_WRITE, 8'd255, 24'h00FF00, 1'b1);
    send_beat(OP_COLORIZE, 8'd223, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd239, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd255, 24'h0, 1'b0);
    send_beat(OP_COLORIZE, 8'd255, 24'h0, 1'b1);
    send_beat(OP_COLORIZE, 8'd207, 24'h0, 1'b0);
  endtask

  task automatic test_random_phases();
    cfg_t        s;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic        first;
    for (int ph = 0; ph < 6; ph++) begin
      s = random_settings();
      case (ph)
        1: begin
          s.material_colors = 64'd0;
          s.alpha_values = 32'd0;
          s.base_alpha = 8'd0;
          s.rust_data = 32'd0;
          s.key_color = 16'hFFFF;
          s.allow_regular = 1'b1;
        end
        2: begin
          s.material_colors = {64{1'b1}};
          s.alpha_values = 32'hFFFF_FFFF;
          s.base_alpha = 8'hFF;
          s.rust_data = 32'hFFFF_FFFF;
          s.key_color = 16'h0000;
          s.allow_regular = 1'b0;
        end
        3: begin
          s.rust_data = $urandom | 32'h0303_0303;
          s.key_color = 16'hF81F;
          s.allow_regular = 1'b1;
        end
        default: ;
      endcase
      if (ph < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct = 71;
      end else if (ph < 4) begin
        tx_idle_pct = 71;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_drained();
      apply_settings(s);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        rgb = 24'($urandom);
        if ($urandom_range(99) < 15) begin
          send_beat(OP_PALETTE_WRITE, 8'($urandom), rgb, 1'($urandom));
        end else begin
          // Mostly long images: a seed reload now and then, then a run of pixels.
          first = ($urandom_range(99) < 4);
          if ($urandom_range(1) == 1)
            idx = 8'($urandom_range(255, 192));
          else if (!active_cfg.allow_regular)
            idx = 8'($urandom_range(191));
          else
            idx = 8'(written_regular[$urandom_range(written_regular.size() - 1)]);
          send_beat(OP_COLORIZE, idx, rgb, first);
        end
      end
    end
  endtask

  initial begin
    active_cfg.material_colors = 64'd0;
    active_cfg.alpha_values = 32'hFFFF_FFFF;
    active_cfg.base_alpha = 8'hFF;
    active_cfg.rust_data = 32'd0;
    active_cfg.key_color = 16'hF81F;
    active_cfg.allow_regular = 1'b1;
    for (int i = 0; i < 256; i++) begin
      palette_shadow[i] = 24'd0;
      palette_written[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) rust_seed[i] = 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_extremes();
    test_materials_and_shades();
    test_rust_effect();
    test_random_phases();
    wait_drained();
    $display("Checked %0d pixels (%0d material, %0d dimmed by rust) and %0d palette writes",
             pixels_checked, material_pixels, rust_dims, palette_writes);
    $display("across %0d register settings, with and without stalls on either side.",
             settings_applied);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d pixels outstanding.", expected_pixels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: indexed_pixel_colorizer.f
+incdir+rtl/core
rtl/core/ipc_pkg.sv
rtl/core/ipc_queue.sv
rtl/core/ipc_front.sv
rtl/core/ipc_back.sv
rtl/core/indexed_pixel_colorizer.sv
sim/indexed_pixel_colorizer_tb.sv
